>>> sv/pairwise_gravity_acceleration_2d_core_defines.svh
// Assertion macros for the pairwise gravity acceleration core checker.
// Depends on a clk and rst in the scope that uses them.
`ifndef PAIRWISE_GRAVITY_ACCELERATION_2D_CORE_DEFINES_SVH
`define PAIRWISE_GRAVITY_ACCELERATION_2D_CORE_DEFINES_SVH

// Antecedent in one cycle implies consequent in the same cycle.
`define PGA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pga check failed");

// Antecedent in one cycle implies consequent in the next cycle.
`define PGA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pga check failed");

`endif

>>> sv/pga_pkg.sv
// Shared widths, constants and item types for the pairwise gravity core.
// No dependencies.
package pga_pkg;
  localparam int DEF_FRAC_BITS = 16;
  localparam int ACC_W  = 32;
  localparam int DIFF_W = 33;
  localparam int SQ_W   = 66;
  localparam int ROOT_W = 34;
  localparam int GM_W   = 64;
  localparam int DEN_W  = 99;
  localparam int PROD_W = 97;
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam logic [ACC_W-1:0] ACC_MAX = 32'h7fff_ffff;
  localparam logic [ACC_W-1:0] ACC_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [ACC_W-1:0]  mass;
    logic [DIFF_W-1:0] ax;
    logic [DIFF_W-1:0] ay;
    logic              neg_x;   // result component is negative
    logic              neg_y;
    logic              zero_x;
    logic              zero_y;
    logic              coin;
  } pga_item_t;

  typedef struct packed {
    logic [GM_W-1:0]   gm;
    logic [DIFF_W-1:0] ax;
    logic [DIFF_W-1:0] ay;
    logic              neg_x;
    logic              neg_y;
    logic              zero_x;
    logic              zero_y;
    logic              coin;
  } pga_carry_t;
endpackage

>>> sv/pairwise_gravity_acceleration_2d_core.sv
// Path from the accepting edge to out_valid: input stage, queue, squares, sum,
// 34-stage square root, three product stages, 33-stage dividers, output register.
// One request per cycle while the back pipeline advances, which it does whenever the
// output register is empty or being taken. Reset clears all valid state and
// sets grav_constant to 1.0 in FRAC_BITS fixed point.
module pairwise_gravity_acceleration_2d_core #(
  parameter int FRAC_BITS = pga_pkg::DEF_FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              grav_constant_we,
  input  logic [31:0]       grav_constant,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [31:0]       source_mass,
  input  logic signed [31:0] pos1_x,
  input  logic signed [31:0] pos1_y,
  input  logic signed [31:0] pos2_x,
  input  logic signed [31:0] pos2_y,
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [31:0] accel_x,
  output logic signed [31:0] accel_y,
  output logic              coincident,
  output logic              saturated
);
  import pga_pkg::*;

  logic [ACC_W-1:0] grav;
  logic             f_valid, f_ready, b_valid, b_ready;
  pga_item_t        f_item, b_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      grav <= ACC_W'(1) << FRAC_BITS;
    end else if (grav_constant_we) begin
      grav <= grav_constant;
    end
  end

  pga_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .source_mass(source_mass), .pos1_x(pos1_x), .pos1_y(pos1_y),
    .pos2_x(pos2_x), .pos2_y(pos2_y),
    .item_valid(f_valid), .item_ready(f_ready), .item(f_item)
  );

  pga_fifo u_fifo (
    .clk(clk), .rst(rst), .push_valid(f_valid), .push_ready(f_ready),
    .push_item(f_item), .pop_valid(b_valid), .pop_ready(b_ready), .pop_item(b_item)
  );

  pga_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .item_valid(b_valid), .item_ready(b_ready),
    .item(b_item), .grav(grav), .out_valid(out_valid), .out_ready(out_ready),
    .accel_x(accel_x), .accel_y(accel_y), .coincident(coincident),
    .saturated(saturated)
  );
endmodule

>>> sv/pga_front.sv
// Front part: accepts a request, forms the position differences and flags.
// Depends on pga_pkg.
module pga_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [31:0]              source_mass,
  input  logic signed [31:0]       pos1_x,
  input  logic signed [31:0]       pos1_y,
  input  logic signed [31:0]       pos2_x,
  input  logic signed [31:0]       pos2_y,
  output logic                     item_valid,
  input  logic                     item_ready,
  output pga_pkg::pga_item_t       item
);
  import pga_pkg::*;

  logic signed [DIFF_W-1:0] dx, dy;
  pga_item_t item_next;

  assign dx = {pos1_x[31], pos1_x} - {pos2_x[31], pos2_x};
  assign dy = {pos1_y[31], pos1_y} - {pos2_y[31], pos2_y};

  always_comb begin
    item_next.mass   = source_mass;
    item_next.ax     = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
    item_next.ay     = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
    item_next.zero_x = (dx == '0);
    item_next.zero_y = (dy == '0);
    item_next.neg_x  = !dx[DIFF_W-1] && (dx != '0);
    item_next.neg_y  = !dy[DIFF_W-1] && (dy != '0);
    item_next.coin   = (dx == '0) && (dy == '0);
  end

  assign in_ready = !item_valid || item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= item_next;
    end
  end
endmodule

>>> sv/pga_fifo.sv
// Short queue between front and back parts.
// Depends on pga_pkg.
module pga_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  pga_pkg::pga_item_t push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output pga_pkg::pga_item_t pop_item
);
  import pga_pkg::*;

  pga_item_t            mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [Q_PTR_W:0]     count;
  logic                 push, pop;

  assign push_ready = (count != (Q_PTR_W+1)'(Q_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (Q_PTR_W+1)'(push) - (Q_PTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end
endmodule

>>> sv/pga_div.sv
// Pipelined restoring divider for one component, one quotient bit a stage,
// with saturation and sign applied at the end. Depends on pga_pkg.
module pga_div #(
  parameter int FRAC_BITS = pga_pkg::DEF_FRAC_BITS
) (
  input  logic                                               clk,
  input  logic                                               en,
  input  logic [pga_pkg::PROD_W+FRAC_BITS:0]                 num,
  input  logic [pga_pkg::DEN_W-1:0]                          den,
  input  logic                                               neg,
  input  logic                                               force_zero,
  output logic signed [pga_pkg::ACC_W-1:0]                   result,
  output logic                                               sat
);
  import pga_pkg::*;

  localparam int NW = PROD_W + FRAC_BITS + 1;
  localparam int CW = DEN_W + ACC_W;

  logic [NW-1:0]    rem [ACC_W+1];
  logic [ACC_W-1:0] quo [ACC_W+1];
  logic [DEN_W-1:0] dn  [ACC_W+1];
  logic             big [ACC_W+1];
  logic             ng  [ACC_W+1];
  logic             fz  [ACC_W+1];
  logic [ACC_W-1:0] qf;
  logic             over;

  // quotient of 2^32 or more always clips; otherwise 32 bits suffice
  always_ff @(posedge clk) begin
    if (en) begin
      big[0] <= (CW'(num) >= (CW'(den) << ACC_W));
      rem[0] <= num;
      quo[0] <= '0;
      dn[0]  <= den;
      ng[0]  <= neg;
      fz[0]  <= force_zero;
    end
  end

  for (genvar j = 1; j <= ACC_W; j++) begin : g_stage
    localparam int BIT = ACC_W - j;
    logic [CW-1:0] sh;
    logic          take;
    assign sh   = CW'(dn[j-1]) << BIT;
    assign take = !big[j-1] && (CW'(rem[j-1]) >= sh);
    always_ff @(posedge clk) begin
      if (en) begin
        rem[j] <= take ? NW'(CW'(rem[j-1]) - sh) : rem[j-1];
        quo[j] <= take ? (quo[j-1] | (ACC_W'(1) << BIT)) : quo[j-1];
        big[j] <= big[j-1];
        dn[j]  <= dn[j-1];
        ng[j]  <= ng[j-1];
        fz[j]  <= fz[j-1];
      end
    end
  end

  assign qf = quo[ACC_W];

  always_comb begin
    if (ng[ACC_W]) begin
      over = big[ACC_W] || (qf[ACC_W-1] && (qf[ACC_W-2:0] != '0));
    end else begin
      over = big[ACC_W] || qf[ACC_W-1];
    end
    sat = !fz[ACC_W] && over;
    if (fz[ACC_W]) begin
      result = '0;
    end else if (over) begin
      result = ng[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      result = ng[ACC_W] ? -qf : qf;
    end
  end
endmodule

>>> sv/pga_back.sv
// Back part: squares, pipelined integer square root, denominator and
// numerators, two dividers and the output register. Depends on pga_pkg, pga_div.
module pga_back #(
  parameter int FRAC_BITS = pga_pkg::DEF_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  pga_pkg::pga_item_t                item,
  input  logic [pga_pkg::ACC_W-1:0]         grav,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [pga_pkg::ACC_W-1:0]  accel_x,
  output logic signed [pga_pkg::ACC_W-1:0]  accel_y,
  output logic                              coincident,
  output logic                              saturated
);
  import pga_pkg::*;

  localparam int NW      = PROD_W + FRAC_BITS + 1;
  localparam int DIV_LAT = ACC_W + 1;
  localparam int PRE_LAT = ROOT_W + 5;
  localparam int TOT     = PRE_LAT + DIV_LAT;
  localparam int TW      = SQ_W + 2;
  localparam int HW      = SQ_W / 2;

  logic                adv;
  logic [TOT-1:0]      vld;
  logic [DIV_LAT-1:0]  cdl;

  logic [SQ_W-1:0]     sqx, sqy;
  pga_carry_t          c0;
  logic [SQ_W-1:0]     sq_rem  [ROOT_W+1];
  logic [ROOT_W-1:0]   sq_root [ROOT_W+1];
  logic [SQ_W-1:0]     sq_d2   [ROOT_W+1];
  pga_carry_t          sq_c    [ROOT_W+1];

  logic [SQ_W-1:0]     p_lo, p_hi;
  logic [GM_W:0]       nxl, nxh, nyl, nyh;
  pga_carry_t          c36, c37, c38;
  logic [DEN_W-1:0]    den37, den38;
  logic [PROD_W-1:0]   nx37, ny37;
  logic [NW-1:0]       numx, numy;
  logic signed [ACC_W-1:0] rx, ry;
  logic                satx, saty;

  assign adv        = !out_valid || out_ready;
  assign item_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[TOT-2:0], item_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sqx       <= SQ_W'(item.ax) * SQ_W'(item.ax);
      sqy       <= SQ_W'(item.ay) * SQ_W'(item.ay);
      c0.gm     <= GM_W'(grav) * GM_W'(item.mass);
      c0.ax     <= item.ax;
      c0.ay     <= item.ay;
      c0.neg_x  <= item.neg_x;
      c0.neg_y  <= item.neg_y;
      c0.zero_x <= item.zero_x;
      c0.zero_y <= item.zero_y;
      c0.coin   <= item.coin;
      sq_rem[0]  <= sqx + sqy;
      sq_d2[0]   <= sqx + sqy;
      sq_root[0] <= '0;
      sq_c[0]    <= c0;
    end
  end

  // one root bit a stage; remainder holds d2 - root^2
  for (genvar k = 1; k <= ROOT_W; k++) begin : g_sqrt
    localparam int BIT = ROOT_W - k;
    logic [TW-1:0] trial;
    logic          take;
    assign trial = (TW'(sq_root[k-1]) << (BIT + 1)) + (TW'(1) << (2 * BIT));
    assign take  = (TW'(sq_rem[k-1]) >= trial);
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_rem[k]  <= take ? SQ_W'(TW'(sq_rem[k-1]) - trial) : sq_rem[k-1];
        sq_root[k] <= take ? (sq_root[k-1] | (ROOT_W'(1) << BIT)) : sq_root[k-1];
        sq_d2[k]   <= sq_d2[k-1];
        sq_c[k]    <= sq_c[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_lo  <= SQ_W'(sq_d2[ROOT_W][HW-1:0]) * SQ_W'(sq_root[ROOT_W][HW-1:0]);
      p_hi  <= SQ_W'(sq_d2[ROOT_W][SQ_W-1:HW]) * SQ_W'(sq_root[ROOT_W][HW-1:0]);
      nxl   <= (GM_W+1)'(sq_c[ROOT_W].gm[ACC_W-1:0]) * (GM_W+1)'(sq_c[ROOT_W].ax);
      nxh   <= (GM_W+1)'(sq_c[ROOT_W].gm[GM_W-1:ACC_W]) * (GM_W+1)'(sq_c[ROOT_W].ax);
      nyl   <= (GM_W+1)'(sq_c[ROOT_W].gm[ACC_W-1:0]) * (GM_W+1)'(sq_c[ROOT_W].ay);
      nyh   <= (GM_W+1)'(sq_c[ROOT_W].gm[GM_W-1:ACC_W]) * (GM_W+1)'(sq_c[ROOT_W].ay);
      c36   <= sq_c[ROOT_W];
      den37 <= DEN_W'(p_lo) + (DEN_W'(p_hi) << HW);
      nx37  <= PROD_W'(nxl) + (PROD_W'(nxh) << ACC_W);
      ny37  <= PROD_W'(nyl) + (PROD_W'(nyh) << ACC_W);
      c37   <= c36;
      numx  <= (NW'(nx37) << FRAC_BITS) + NW'(den37 >> 1);
      numy  <= (NW'(ny37) << FRAC_BITS) + NW'(den37 >> 1);
      den38 <= den37;
      c38   <= c37;
      cdl   <= {cdl[DIV_LAT-2:0], c38.coin};
    end
  end

  pga_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk(clk), .en(adv), .num(numx), .den(den38), .neg(c38.neg_x),
    .force_zero(c38.zero_x || c38.coin), .result(rx), .sat(satx)
  );

  pga_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk(clk), .en(adv), .num(numy), .den(den38), .neg(c38.neg_y),
    .force_zero(c38.zero_y || c38.coin), .result(ry), .sat(saty)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld[TOT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      accel_x    <= rx;
      accel_y    <= ry;
      coincident <= cdl[DIV_LAT-1];
      saturated  <= satx || saty;
    end
  end
endmodule

>>> sv/pga_checker.sv
// Port-level checks for the pairwise gravity core, bound to the top level.
// Depends on pairwise_gravity_acceleration_2d_core_defines.svh.
`include "pairwise_gravity_acceleration_2d_core_defines.svh"
module pga_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [31:0] accel_x,
  input logic signed [31:0] accel_y,
  input logic              coincident,
  input logic              saturated
);
  // a stalled result keeps its payload
  `PGA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(accel_x) && $stable(accel_y))
  // coincident results are zero and never clipped
  `PGA_ASSERT_NOW(a_coin_zero, out_valid && coincident, accel_x == 0 && accel_y == 0 && !saturated)
  // a clipped result shows a rail value in some component
  `PGA_ASSERT_NOW(a_sat_rail, out_valid && saturated, accel_x == 32'sh7fffffff || accel_x == 32'sh80000000 || accel_y == 32'sh7fffffff || accel_y == 32'sh80000000)
  // nothing comes out right after reset
  `PGA_ASSERT_NOW(a_reset_empty, $past(rst), !out_valid)
endmodule

bind pairwise_gravity_acceleration_2d_core pga_checker u_pga_checker (.*);
